FILE: sv/obstacle_cost_inflation_top_macros.svh
// Assertion macros for the obstacle cost inflation block.
// Used by obstacle_cost_inflation_top.sv; depends on nothing else.
`ifndef OBSTACLE_COST_INFLATION_TOP_MACROS_SVH
`define OBSTACLE_COST_INFLATION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/oci_pkg.sv
// Shared types and constants of the obstacle cost inflation block.
// Used by oci_recip.sv, obstacle_cost_inflation_top.sv and the testbench; no dependencies.
package oci_pkg;

  localparam int COORD_W     = 8;
  localparam int COST_W      = 8;
  localparam int DIM_W       = 9;
  localparam int WIN_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  // Wide enough for any grid limit up to 4096 columns or rows.
  localparam int LIM_W       = 13;
  localparam int WLIM_W      = 8;
  // Window offsets never exceed 31 in magnitude.
  localparam int OFS_W       = 7;
  // Target coordinates range from -31 to 285.
  localparam int TGT_W       = 10;
  // 255 * 63 needs 14 bits.
  localparam int NUM_W       = 14;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int STEP_W      = 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic [RECIP_W-1:0] recip;
  } recip_res_t;

endpackage

FILE: sv/obstacle_cost_inflation_top.sv
// Top level of the obstacle cost inflation block: cost grid memory, control and stamping.
// Depends on oci_pkg, oci_recip and obstacle_cost_inflation_top_macros.svh.
`include "obstacle_cost_inflation_top_macros.svh"

// The block keeps a grid of 8-bit costs in one synchronous memory of
// 2^(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) cells, cell (x, y) at row y and
// column x. Three operations arrive on the input channel, and every item,
// also one with the unused op code, gives exactly one result transfer. A
// clear writes zero to every cell of the memory, one cell a cycle; the same
// pass runs after reset, and no input transfer is taken until it ends, while
// configuration writes are taken at any time. A mark first works out the
// reciprocal of the window side s in a bit-serial unit, which the sequencer
// waits for, then walks the window one cell a cycle through a read,
// multiply, compare and write-back pipeline, and waits for that pipeline to
// drain. With h = floor(s/2) the window covers 2h by 2h cells (a window of 1
// covers one cell). The stamped cost is 255 * (s - d) / s, rounded down,
// with d the Manhattan distance from the obstacle, computed exactly as a
// multiplication by the rounded-up reciprocal; a cell keeps the larger of
// its old and its stamped cost, and cells outside the grid in use are
// skipped. A read passes through an issue state and a data state. Every cell
// of one mark is a distinct memory entry, and the next operation starts only
// when the pipeline is empty, so no read can meet a pending write to the
// same entry. A finished result waits in an output register, and the next
// item is taken meanwhile.
// Configuration may be written only while the block is idle.
module obstacle_cost_inflation_top
  import oci_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_RECIP, S_STAMP, S_DRAIN, S_RD_ISSUE, S_RD_DATA, S_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_height_r;
  logic [WIN_W-1:0] window_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(256);
      grid_height_r <= DIM_W'(256);
      window_size_r <= WIN_W'(9);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        CFG_WINDOW_SIZE: window_size_r <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits after clamping to the built sizes.
  logic [LIM_W-1:0] lim_w;
  logic [LIM_W-1:0] lim_h;
  logic [WIN_W-1:0] win_s;
  logic [WIN_W-1:0] half;
  logic [WIN_W-1:0] half_hi;

  assign lim_w = (LIM_W'(grid_width_r) > LIM_W'(MAX_WIDTH)) ?
                 LIM_W'(MAX_WIDTH) : LIM_W'(grid_width_r);
  assign lim_h = (LIM_W'(grid_height_r) > LIM_W'(MAX_HEIGHT)) ?
                 LIM_W'(MAX_HEIGHT) : LIM_W'(grid_height_r);
  assign win_s = (WLIM_W'(window_size_r) > WLIM_W'(MAX_WINDOW)) ?
                 WIN_W'(MAX_WINDOW) : window_size_r;
  assign half    = win_s >> 1;
  assign half_hi = (half == '0) ? '0 : half - 1'b1;

  logic signed [OFS_W-1:0] ofs_lo;
  logic signed [OFS_W-1:0] ofs_hi;

  assign ofs_lo = -signed'(OFS_W'(half));
  assign ofs_hi = signed'(OFS_W'(half_hi));

  // Input transfer and the bounds test of the given cell.
  logic in_fire;
  logic in_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_ok    = (LIM_W'(in_data.cell_x) < lim_w) && (LIM_W'(in_data.cell_y) < lim_h);

  // Reciprocal unit, started when an in-range mark with a non-zero window arrives.
  logic       recip_start;
  recip_res_t recip;

  assign recip_start = in_fire && (in_data.op == OP_MARK) && in_ok && (win_s != '0);

  oci_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start),
    .divisor (win_s),
    .res     (recip)
  );

  // Item and window walk state.
  in_item_t                item_r;
  logic [RECIP_W-1:0]      recip_r;
  logic signed [OFS_W-1:0] dx_r;
  logic signed [OFS_W-1:0] dy_r;
  logic [AW-1:0]           sweep_r;
  logic [COST_W-1:0]       res_cost_r;
  logic                    res_oor_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // Target cell of the current offset.
  logic signed [TGT_W-1:0] tx;
  logic signed [TGT_W-1:0] ty;
  logic                    tgt_ok;
  logic [WIN_W-1:0]        adx;
  logic [WIN_W-1:0]        ady;
  logic [WIN_W-1:0]        man_dist;
  logic [WIN_W-1:0]        span;
  logic [AW-1:0]           tgt_addr;
  logic                    walk_last_x;
  logic                    walk_last;

  assign tx = signed'(TGT_W'(item_r.cell_x)) + TGT_W'(dx_r);
  assign ty = signed'(TGT_W'(item_r.cell_y)) + TGT_W'(dy_r);
  assign tgt_ok = !tx[TGT_W-1] && !ty[TGT_W-1] &&
                  (LIM_W'(tx[TGT_W-2:0]) < lim_w) && (LIM_W'(ty[TGT_W-2:0]) < lim_h);
  assign adx  = dx_r[OFS_W-1] ? WIN_W'(-dx_r) : WIN_W'(dx_r);
  assign ady  = dy_r[OFS_W-1] ? WIN_W'(-dy_r) : WIN_W'(dy_r);
  assign man_dist = adx + ady;
  assign span = win_s - man_dist;
  assign tgt_addr = {YW'(ty[TGT_W-2:0]), XW'(tx[TGT_W-2:0])};
  assign walk_last_x = (dx_r == ofs_hi);
  assign walk_last   = walk_last_x && (dy_r == ofs_hi);

  // Read-modify-write pipeline: stage one holds the read address and the
  // numerator 255 * (s - d), stage two the product and the old cost.
  logic                 p1_vld_r;
  logic [AW-1:0]        p1_addr_r;
  logic [NUM_W-1:0]     p1_num_r;
  logic                 p2_vld_r;
  logic [AW-1:0]        p2_addr_r;
  logic [PROD_W-1:0]    p2_prod_r;
  logic [COST_W-1:0]    p2_old_r;
  logic [NUM_W-1:0]     num_nxt;
  logic [COST_W-1:0]    stamp_cost;
  logic                 p1_vld_nxt;

  assign num_nxt    = NUM_W'({span, 8'd0}) - NUM_W'(span);
  assign p1_vld_nxt = (state_r == S_STAMP) && tgt_ok;
  assign stamp_cost = p2_prod_r[RECIP_SHIFT +: COST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= p1_vld_nxt;
      p2_vld_r <= p1_vld_r;
    end
  end

  // Cost memory with its read data registered.
  logic [COST_W-1:0] mem [2**AW];
  logic [COST_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [COST_W-1:0] wr_data;

  assign rd_addr = (state_r == S_STAMP) ? tgt_addr :
                   {YW'(item_r.cell_y), XW'(item_r.cell_x)};

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = p2_addr_r;
    wr_data = stamp_cost;
    if (state_r == S_INIT || state_r == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else if (p2_vld_r && (stamp_cost > p2_old_r)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= tgt_addr;
    p1_num_r  <= num_nxt;
    p2_addr_r <= p1_addr_r;
    p2_old_r  <= rd_data_r;
    p2_prod_r <= PROD_W'(p1_num_r) * PROD_W'(recip_r);
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      res_cost_r  <= '0;
      res_oor_r   <= 1'b0;
    end else begin
      // In the finish state the output register is reloaded below instead.
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_r     <= in_data;
            res_cost_r <= '0;
            res_oor_r  <= 1'b0;
            sweep_r    <= '0;
            case (in_data.op)
              OP_CLEAR: state_r <= S_CLEAR;
              OP_MARK: begin
                if (!in_ok) begin
                  res_oor_r <= 1'b1;
                  state_r   <= S_FINISH;
                end else if (win_s == '0) begin
                  state_r <= S_FINISH;
                end else begin
                  state_r <= S_RECIP;
                end
              end
              OP_READ: begin
                if (!in_ok) begin
                  res_oor_r <= 1'b1;
                  state_r   <= S_FINISH;
                end else begin
                  state_r <= S_RD_ISSUE;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == '1) begin
            state_r <= S_FINISH;
          end
        end
        S_RECIP: begin
          if (recip.done) begin
            recip_r <= recip.recip;
            dx_r    <= ofs_lo;
            dy_r    <= ofs_lo;
            state_r <= S_STAMP;
          end
        end
        S_STAMP: begin
          if (walk_last) begin
            state_r <= S_DRAIN;
          end else if (walk_last_x) begin
            dx_r <= ofs_lo;
            dy_r <= dy_r + 1'b1;
          end else begin
            dx_r <= dx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!p1_vld_r && !p2_vld_r) begin
            state_r <= S_FINISH;
          end
        end
        S_RD_ISSUE: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          res_cost_r <= rd_data_r;
          state_r    <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.cost         <= res_cost_r;
            out_data_r.out_of_range <= res_oor_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The memory is never written while a new item could be taken.
  `OCI_ASSERT_NOW(a_no_write_when_ready, clk, rst_n, mem_we, !in_ready, "memory written while idle")
  // Stamping pipeline entries exist only while a mark walks or drains.
  `OCI_ASSERT_NOW(a_pipe_in_mark, clk, rst_n, p2_vld_r, (state_r == S_STAMP || state_r == S_DRAIN), "stamp pipeline busy outside a mark")
  // The reciprocal unit finishes only while the sequencer waits for it.
  `OCI_ASSERT_NOW(a_recip_expected, clk, rst_n, recip.done, (state_r == S_RECIP), "unexpected reciprocal")
  // A result loaded from the finish state is presented in the next cycle.
  `OCI_ASSERT_NEXT(a_finish_loads, clk, rst_n, (state_r == S_FINISH) && (!out_valid_r || out_ready), out_valid && in_ready, "finished result not presented")

endmodule

FILE: sv/oci_recip.sv
// Bit-serial reciprocal unit: ceil(2^RECIP_SHIFT / s) for a window side s.
// Depends on oci_pkg.
module oci_recip
  import oci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIN_W-1:0] divisor,
  output recip_res_t       res
);

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [WIN_W-1:0]       rem_r;
  logic [RECIP_SHIFT-1:0] quo_r;
  logic [WIN_W:0]         trial;
  logic                   fits;

  // Restoring division of 2^RECIP_SHIFT - 1 (all ones) by s, one bit a cycle;
  // the quotient plus one is the rounded-up reciprocal.
  assign trial = {rem_r, 1'b1};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(RECIP_SHIFT - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? WIN_W'(trial - {1'b0, divisor}) : WIN_W'(trial);
      quo_r <= {quo_r[RECIP_SHIFT-2:0], fits};
    end
  end

  assign res.done  = done_r;
  assign res.recip = RECIP_W'(quo_r) + RECIP_W'(1);

endmodule

FILE: tb/obstacle_cost_inflation_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for obstacle_cost_inflation_top: clear, mark and read transfers.
// Depends on oci_pkg and the RTL of the block only; carries its own cost grid predictor.
module obstacle_cost_inflation_top_tb;
  import oci_pkg::*;

  // Sizes of the block as instantiated with its default parameters.
  localparam int GRID_MAX       = 256;
  localparam int WIN_MAX        = 63;
  localparam int FULL_COST      = 255;
  // The longest quiet stretch is a clear pass over all 65536 cells, which may
  // follow the clear after reset; a mark with the widest window is far shorter.
  localparam int WATCHDOG_LIMIT = 300000;

  // The op code that the block treats as a no-operation, and a register index
  // that it ignores.
  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  obstacle_cost_inflation_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the block's state: the cost grid and the three registers, as
  // they stand after every transfer that has been accepted so far.
  logic [COST_W-1:0]  cost_grid [0:GRID_MAX*GRID_MAX-1];
  logic [DIM_W-1:0]   width_reg  = 9'd256;
  logic [DIM_W-1:0]   height_reg = 9'd256;
  logic [WIN_W-1:0]   window_reg = 6'd9;

  // Costs still owed by the block, oldest first.
  out_item_t          owed_costs [$];
  int                 mismatch_count = 0;
  int                 quiet_cycles   = 0;

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a result.
  int                 send_gap_pct   = 0;
  int                 recv_stall_pct = 0;

  // Recent obstacle positions, so that reads and further marks land where
  // the grid actually holds something.
  int                 mark_xs [$];
  int                 mark_ys [$];

  // Directed stimulus: register writes and items, some with the result
  // written out by hand.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  plan_row_t directed_plan [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int eff_width();
    return (width_reg > GRID_MAX) ? GRID_MAX : int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg > GRID_MAX) ? GRID_MAX : int'(height_reg);
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && y >= 0 && x < eff_width() && y < eff_height();
  endfunction

  // Applies one item to the shadow grid and returns the result it earns.
  // The window runs from -h to max(h-1, 0) on each axis, and each covered
  // cell keeps the larger of its old cost and 255 * (s - d) / s.
  function automatic out_item_t apply_op(input in_item_t it);
    out_item_t res;
    int        s;
    int        h;
    int        hi;
    int        tx;
    int        ty;
    int        d;
    int        c;
    res = '0;
    case (it.op)
      OP_CLEAR: begin
        foreach (cost_grid[i]) cost_grid[i] = '0;
      end
      OP_MARK: begin
        if (!on_grid(it.cell_x, it.cell_y)) begin
          res.out_of_range = 1'b1;
        end else begin
          s  = (window_reg > WIN_MAX) ? WIN_MAX : int'(window_reg);
          h  = s / 2;
          hi = (h - 1 < 0) ? 0 : h - 1;
          if (s != 0) begin
            for (int dy = -h; dy <= hi; dy++) begin
              for (int dx = -h; dx <= hi; dx++) begin
                tx = int'(it.cell_x) + dx;
                ty = int'(it.cell_y) + dy;
                d  = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
                if (on_grid(tx, ty) && d <= s) begin
                  c = (FULL_COST * (s - d)) / s;
                  if (c > cost_grid[ty*GRID_MAX + tx]) cost_grid[ty*GRID_MAX + tx] = c[COST_W-1:0];
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        if (on_grid(it.cell_x, it.cell_y)) res.cost = cost_grid[it.cell_y*GRID_MAX + it.cell_x];
        else res.out_of_range = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void add_item(input logic [1:0] op, input int x, input int y,
                                   input bit typed, input int cost, input bit oor);
    plan_row_t row;
    row                   = '{default: '0};
    row.item.op           = op;
    row.item.cell_x       = x[COORD_W-1:0];
    row.item.cell_y       = y[COORD_W-1:0];
    row.typed             = typed;
    row.want.cost         = cost[COST_W-1:0];
    row.want.out_of_range = oor;
    directed_plan = {directed_plan, row};
  endfunction

  // A grid side for the random part: mostly in range, with the zero, unit,
  // full and oversize extremes mixed in.
  function automatic logic [DIM_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(257, 511));
    if (r == 2) return DIM_W'(GRID_MAX);
    if (r == 3) return DIM_W'(1);
    if (r < 8) return DIM_W'($urandom_range(2, 8));
    return DIM_W'($urandom_range(9, GRID_MAX));
  endfunction

  // A random mark, read or no-op. Half of the cells sit around a recent
  // obstacle, most of the rest inside the grid in use, a few anywhere.
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       k;
    int       span;
    r         = $urandom_range(0, 99);
    it.op     = (r < 3) ? OP_UNUSED : ((r < 48) ? OP_MARK : OP_READ);
    it.cell_x = COORD_W'($urandom_range(0, 255));
    it.cell_y = COORD_W'($urandom_range(0, 255));
    if (mark_xs.size() > 0 && $urandom_range(0, 1) == 1) begin
      k         = $urandom_range(0, mark_xs.size() - 1);
      span      = window_reg / 2 + 1;
      it.cell_x = COORD_W'(mark_xs[k] + int'($urandom_range(0, 2 * span)) - span);
      it.cell_y = COORD_W'(mark_ys[k] + int'($urandom_range(0, 2 * span)) - span);
    end else if ($urandom_range(0, 9) != 0 && eff_width() > 0 && eff_height() > 0) begin
      it.cell_x = COORD_W'($urandom_range(0, eff_width() - 1));
      it.cell_y = COORD_W'($urandom_range(0, eff_height() - 1));
    end
    if (it.op == OP_MARK) begin
      mark_xs = {mark_xs, int'(it.cell_x)};
      mark_ys = {mark_ys, int'(it.cell_y)};
      if (mark_xs.size() > 8) begin
        void'(mark_xs.pop_front());
        void'(mark_ys.pop_front());
      end
    end
    return it;
  endfunction

  // Offers one item and waits for its transfer. Valid is only lowered for a
  // gap, so back-to-back items keep it high without a glitch. The result is
  // worked out at the transfer; a hand-written one replaces it when given.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_op(it);
    owed_costs = {owed_costs, (typed ? want : predicted)};
  endtask

  // Lets the block run dry. Every item earns exactly one result, so an empty
  // queue means the block is idle; an extra wait after it covers the output register.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_costs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  width_reg  = val;
      CFG_GRID_HEIGHT: height_reg = val;
      CFG_WINDOW_SIZE: window_reg = val[WIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // The receiver refuses results at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every result transfer is held against the oldest cost still owed.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_costs.size() == 0) begin
        report_mismatch($sformatf("result cost=%0d oor=%0b with nothing owed",
                                  out_data.cost, out_data.out_of_range));
      end else begin
        want = owed_costs.pop_front();
        if (out_data.cost !== want.cost)
          report_mismatch($sformatf("cost %0d, expected %0d", out_data.cost, want.cost));
        if (out_data.out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                    out_data.out_of_range, want.out_of_range));
      end
    end
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("obstacle_cost_inflation_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t  it;
    int        s;
    int        n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    foreach (cost_grid[i]) cost_grid[i] = '0;

    // Default registers: a 256 by 256 grid and a window of nine.
    add_item(OP_READ,    0,   0, 1,   0, 0);   // untouched grid after reset
    add_item(OP_MARK,   10,  10, 1,   0, 0);
    add_item(OP_READ,   10,  10, 1, 255, 0);   // the obstacle cell itself
    add_item(OP_READ,    6,   6, 0,   0, 0);   // far corner of the window
    add_item(OP_READ,   13,  13, 0,   0, 0);   // near corner of the window
    add_item(OP_READ,   14,  10, 0,   0, 0);   // just past the upper offset
    add_item(OP_MARK,    0,   0, 1,   0, 0);   // window clipped at the origin
    add_item(OP_READ,    0,   0, 1, 255, 0);
    add_item(OP_MARK,  255, 255, 1,   0, 0);   // window clipped at the far corner
    add_item(OP_READ,  255, 255, 1, 255, 0);
    add_item(OP_READ,  252, 254, 0,   0, 0);
    add_item(OP_UNUSED, 255, 255, 1,  0, 0);   // unused op code does nothing
    add_item(OP_CLEAR,   0,   0, 1,   0, 0);
    add_item(OP_READ,   10,  10, 1,   0, 0);   // cleared
    // A tiny grid: the mark is clipped and cells beyond the edges are flagged.
    add_cfg(CFG_GRID_WIDTH, 9'd5);
    add_cfg(CFG_GRID_HEIGHT, 9'd3);
    add_item(OP_MARK,    4,   2, 1,   0, 0);
    add_item(OP_MARK,    5,   0, 1,   0, 1);   // mark outside the grid
    add_item(OP_READ,    0,   3, 1,   0, 1);   // read outside the grid
    add_item(OP_READ,    2,   2, 0,   0, 0);
    // Zero width puts every cell out of range.
    add_cfg(CFG_GRID_WIDTH, 9'd0);
    add_item(OP_READ,    0,   0, 1,   0, 1);
    // Oversize width is taken as the full grid; a zero window stamps nothing.
    add_cfg(CFG_GRID_WIDTH, 9'd300);
    add_cfg(CFG_GRID_HEIGHT, 9'd256);
    add_cfg(CFG_WINDOW_SIZE, 9'd0);
    add_item(OP_MARK,  100, 100, 1,   0, 0);
    add_item(OP_READ,  100, 100, 0,   0, 0);
    // A window of one covers only the obstacle cell.
    add_cfg(CFG_WINDOW_SIZE, 9'd1);
    add_item(OP_MARK,   50,  50, 1,   0, 0);
    add_item(OP_READ,   50,  50, 1, 255, 0);
    // The widest window, corner cell at distance 62.
    add_cfg(CFG_WINDOW_SIZE, 9'd63);
    add_item(OP_MARK,  128, 128, 1,   0, 0);
    add_item(OP_READ,   97,  97, 0,   0, 0);
    // The unused register index is ignored; upper data bits of the window
    // register are dropped.
    add_cfg(CFG_UNUSED, 9'h1FF);
    add_cfg(CFG_WINDOW_SIZE, 9'h1C2);
    add_item(OP_MARK,   20,  20, 1,   0, 0);
    add_item(OP_READ,   19,  19, 0,   0, 0);

    @(posedge clk);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random part in three phases: a slow receiver, then a slow sender, then
    // full throughput. Each phase runs through several register settings,
    // written only once the block has gone quiet, and clears the grid once.
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 30 : ((phase == 1) ? 68 : 0);
      recv_stall_pct = (phase == 0) ? 68 : ((phase == 1) ? 30 : 0);
      for (int blk = 0; blk < 8; blk++) begin
        drain();
        write_reg(CFG_GRID_WIDTH, pick_side());
        write_reg(CFG_GRID_HEIGHT, pick_side());
        case ($urandom_range(0, 15))
          0:       s = 0;
          1:       s = WIN_MAX;
          2:       s = $urandom_range(32, WIN_MAX - 1);
          3:       s = 1;
          default: s = $urandom_range(2, 15);
        endcase
        write_reg(CFG_WINDOW_SIZE, {3'($urandom_range(0, 7)), 6'(s)});
        // Wide windows stamp thousands of cells per mark, so keep those runs short.
        n = (s >= 32) ? 12 : 82;
        if (blk == 1) begin
          it        = '0;
          it.op     = OP_CLEAR;
          it.cell_x = COORD_W'($urandom_range(0, 255));
          it.cell_y = COORD_W'($urandom_range(0, 255));
          send_item(it, 1'b0, '0);
        end
        repeat (n) send_item(random_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && owed_costs.size() == 0) begin
      $display("obstacle_cost_inflation_top test passed");
    end else begin
      $display("obstacle_cost_inflation_top test failed");
    end
    $finish;
  end

endmodule

FILE: obstacle_cost_inflation_top.f
+incdir+sv
sv/oci_pkg.sv
sv/oci_recip.sv
sv/obstacle_cost_inflation_top.sv
tb/obstacle_cost_inflation_top_tb.sv
